// ===== rtl/e2q_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// yaw-pitch-roll to quaternion converter. No dependencies.
package e2q_pkg;

    localparam int Q_FRAC = 30;   // CORDIC and product fraction bits
    localparam int DP_W   = 34;   // CORDIC datapath width (Q3.30 plus guard)
    localparam int SC_W   = 32;   // sine/cosine width after the CORDIC
    localparam int PROD_W = 64;   // three-way product width (Q60)

    localparam int LANES      = 3;
    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    localparam int COMPS  = 4;
    localparam int COMP_X = 0;
    localparam int COMP_Y = 1;
    localparam int COMP_Z = 2;
    localparam int COMP_W = 3;

    localparam logic signed [DP_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [DP_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [DP_W-1:0] GAIN_Q30    = 34'sd652032874;

    // One angle lane in flight through the CORDIC
    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [DP_W-1:0] z;
        logic                   neg;
    } lane_t;

    typedef struct packed {
        logic signed [SC_W-1:0] s;
        logic signed [SC_W-1:0] c;
    } sc_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [DP_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [DP_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            5'd24:   v = 34'sd63;
            5'd25:   v = 34'sd31;
            5'd26:   v = 34'sd15;
            5'd27:   v = 34'sd7;
            5'd28:   v = 34'sd3;
            5'd29:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/e2q_if.sv =====
// Valid/ready channel interfaces: angle items in, quaternion items out.
// No dependencies.
interface e2q_angle_if #(
    parameter int ANGLE_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;

    modport source (output valid, output yaw_angle, output pitch_angle,
                    output roll_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle,
                    input roll_angle, output ready);
endinterface

interface e2q_quat_if #(
    parameter int COMPONENT_WIDTH = 16
) ();
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] quat_x;
    logic signed [COMPONENT_WIDTH-1:0] quat_y;
    logic signed [COMPONENT_WIDTH-1:0] quat_z;
    logic signed [COMPONENT_WIDTH-1:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

// ===== rtl/e2q_cordic_stage.sv =====
// One registered CORDIC rotation step for all three angle lanes.
// Depends on e2q_pkg.
module e2q_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              vld_in,
    input  e2q_pkg::lane_t [e2q_pkg::LANES-1:0] lanes_in,
    output logic                              vld_out,
    output e2q_pkg::lane_t [e2q_pkg::LANES-1:0] lanes_out
);

    localparam logic [4:0] IDX5 = IDX[4:0];
    localparam logic signed [e2q_pkg::DP_W-1:0] ATAN = e2q_pkg::atan_q30(IDX5);

    logic                                vld_reg;
    e2q_pkg::lane_t [e2q_pkg::LANES-1:0] lanes_reg;
    e2q_pkg::lane_t [e2q_pkg::LANES-1:0] lanes_next;

    always_comb
    begin
        for (int l = 0; l < e2q_pkg::LANES; l++)
        begin
            lanes_next[l].neg = lanes_in[l].neg;
            if (!lanes_in[l].z[e2q_pkg::DP_W-1])
            begin
                lanes_next[l].x = lanes_in[l].x - (lanes_in[l].y >>> IDX);
                lanes_next[l].y = lanes_in[l].y + (lanes_in[l].x >>> IDX);
                lanes_next[l].z = lanes_in[l].z - ATAN;
            end
            else
            begin
                lanes_next[l].x = lanes_in[l].x + (lanes_in[l].y >>> IDX);
                lanes_next[l].y = lanes_in[l].y - (lanes_in[l].x >>> IDX);
                lanes_next[l].z = lanes_in[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lanes_reg <= lanes_next;
    end

    assign vld_out   = vld_reg;
    assign lanes_out = lanes_reg;

endmodule

// ===== rtl/e2q_sincos.sv =====
// Half-angle fold, CORDIC step chain and sign fix-up for three angles.
// Depends on e2q_pkg and e2q_cordic_stage.
module e2q_sincos #(
    parameter int ANGLE_WIDTH       = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        vld_in,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_WIDTH-1:0]  angles,
    output logic                                        vld_out,
    output e2q_pkg::sc_t [e2q_pkg::LANES-1:0]           sc_out
);

    localparam int HSHIFT = 32 - ANGLE_WIDTH;
    localparam int EXT    = e2q_pkg::DP_W - ANGLE_WIDTH;

    e2q_pkg::lane_t [e2q_pkg::LANES-1:0] chain [0:CORDIC_ITERATIONS];
    logic                                chain_vld [0:CORDIC_ITERATIONS];

    e2q_pkg::lane_t [e2q_pkg::LANES-1:0] prep_next;
    e2q_pkg::lane_t [e2q_pkg::LANES-1:0] prep_reg;
    logic                                prep_vld_reg;
    logic signed [e2q_pkg::DP_W-1:0]     h_ang [e2q_pkg::LANES];

    logic                                vld_reg;
    e2q_pkg::sc_t [e2q_pkg::LANES-1:0]   sc_reg;
    e2q_pkg::sc_t [e2q_pkg::LANES-1:0]   sc_next;

    // Half angle in Q30, folded into [-pi/2, pi/2]
    always_comb
    begin
        for (int l = 0; l < e2q_pkg::LANES; l++)
        begin
            h_ang[l] = $signed({{EXT{angles[l][ANGLE_WIDTH-1]}}, angles[l]}) <<< HSHIFT;
            prep_next[l].x = e2q_pkg::GAIN_Q30;
            prep_next[l].y = '0;
            if (h_ang[l] > e2q_pkg::HALF_PI_Q30)
            begin
                prep_next[l].z   = h_ang[l] - e2q_pkg::PI_Q30;
                prep_next[l].neg = 1'b1;
            end
            else if (h_ang[l] < -e2q_pkg::HALF_PI_Q30)
            begin
                prep_next[l].z   = h_ang[l] + e2q_pkg::PI_Q30;
                prep_next[l].neg = 1'b1;
            end
            else
            begin
                prep_next[l].z   = h_ang[l];
                prep_next[l].neg = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_vld_reg <= 1'b0;
        else if (en)
            prep_vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    assign chain[0]     = prep_reg;
    assign chain_vld[0] = prep_vld_reg;

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_step
        e2q_cordic_stage #(
            .IDX (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .vld_in    (chain_vld[i]),
            .lanes_in  (chain[i]),
            .vld_out   (chain_vld[i+1]),
            .lanes_out (chain[i+1])
        );
    end

    // Undo the fold by negating both outputs
    always_comb
    begin
        for (int l = 0; l < e2q_pkg::LANES; l++)
        begin
            if (chain[CORDIC_ITERATIONS][l].neg)
            begin
                sc_next[l].s = e2q_pkg::SC_W'(-chain[CORDIC_ITERATIONS][l].y);
                sc_next[l].c = e2q_pkg::SC_W'(-chain[CORDIC_ITERATIONS][l].x);
            end
            else
            begin
                sc_next[l].s = e2q_pkg::SC_W'(chain[CORDIC_ITERATIONS][l].y);
                sc_next[l].c = e2q_pkg::SC_W'(chain[CORDIC_ITERATIONS][l].x);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= chain_vld[CORDIC_ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sc_reg <= sc_next;
    end

    assign vld_out = vld_reg;
    assign sc_out  = sc_reg;

endmodule

// ===== rtl/e2q_mix.sv =====
// Quaternion assembly: pair products, triple products, sums, round/saturate.
// Depends on e2q_pkg.
module e2q_mix #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              vld_in,
    input  e2q_pkg::sc_t [e2q_pkg::LANES-1:0] sc_in,
    output logic                              vld_out,
    output logic signed [COMPONENT_WIDTH-1:0] quat_x,
    output logic signed [COMPONENT_WIDTH-1:0] quat_y,
    output logic signed [COMPONENT_WIDTH-1:0] quat_z,
    output logic signed [COMPONENT_WIDTH-1:0] quat_w
);

    localparam int PW = e2q_pkg::PROD_W;
    localparam int SW = e2q_pkg::SC_W;
    localparam int SH = 2 * e2q_pkg::Q_FRAC - (COMPONENT_WIDTH - 1);
    localparam logic signed [PW-1:0] RND_HALF = 64'sd1 <<< (SH - 1);
    localparam logic signed [PW-1:0] COMP_HI  = (64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1;
    localparam logic signed [PW-1:0] COMP_LO  = -COMP_HI - 64'sd1;

    // stage A: pair products of yaw and pitch, roll carried along
    logic signed [PW-1:0] pa_cysp, pa_sycp, pa_cycp, pa_sysp;
    logic signed [SW-1:0] cysp_reg, sycp_reg, cycp_reg, sysp_reg, cr_reg, sr_reg;
    logic                 a_vld_reg;

    // stage B: triple products
    logic signed [PW-1:0] prod_reg [8];
    logic                 b_vld_reg;

    // stage C: sums
    logic signed [PW-1:0] sum_reg [e2q_pkg::COMPS];
    logic                 c_vld_reg;

    // stage D: rounded and saturated components
    logic signed [PW-1:0]              rnd [e2q_pkg::COMPS];
    logic signed [COMPONENT_WIDTH-1:0] q_next [e2q_pkg::COMPS];
    logic signed [COMPONENT_WIDTH-1:0] q_reg  [e2q_pkg::COMPS];
    logic                              d_vld_reg;

    assign pa_cysp = sc_in[e2q_pkg::LANE_YAW].c * sc_in[e2q_pkg::LANE_PITCH].s;
    assign pa_sycp = sc_in[e2q_pkg::LANE_YAW].s * sc_in[e2q_pkg::LANE_PITCH].c;
    assign pa_cycp = sc_in[e2q_pkg::LANE_YAW].c * sc_in[e2q_pkg::LANE_PITCH].c;
    assign pa_sysp = sc_in[e2q_pkg::LANE_YAW].s * sc_in[e2q_pkg::LANE_PITCH].s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cysp_reg <= pa_cysp[e2q_pkg::Q_FRAC+SW-1:e2q_pkg::Q_FRAC];
            sycp_reg <= pa_sycp[e2q_pkg::Q_FRAC+SW-1:e2q_pkg::Q_FRAC];
            cycp_reg <= pa_cycp[e2q_pkg::Q_FRAC+SW-1:e2q_pkg::Q_FRAC];
            sysp_reg <= pa_sysp[e2q_pkg::Q_FRAC+SW-1:e2q_pkg::Q_FRAC];
            cr_reg   <= sc_in[e2q_pkg::LANE_ROLL].c;
            sr_reg   <= sc_in[e2q_pkg::LANE_ROLL].s;

            prod_reg[0] <= cysp_reg * cr_reg;
            prod_reg[1] <= sycp_reg * sr_reg;
            prod_reg[2] <= sycp_reg * cr_reg;
            prod_reg[3] <= cysp_reg * sr_reg;
            prod_reg[4] <= cycp_reg * sr_reg;
            prod_reg[5] <= sysp_reg * cr_reg;
            prod_reg[6] <= cycp_reg * cr_reg;
            prod_reg[7] <= sysp_reg * sr_reg;

            sum_reg[e2q_pkg::COMP_X] <= prod_reg[0] + prod_reg[1];
            sum_reg[e2q_pkg::COMP_Y] <= prod_reg[2] - prod_reg[3];
            sum_reg[e2q_pkg::COMP_Z] <= prod_reg[4] - prod_reg[5];
            sum_reg[e2q_pkg::COMP_W] <= prod_reg[6] + prod_reg[7];

            q_reg <= q_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < e2q_pkg::COMPS; k++)
        begin
            rnd[k] = (sum_reg[k] + RND_HALF) >>> SH;
            if (rnd[k] > COMP_HI)
                q_next[k] = COMP_HI[COMPONENT_WIDTH-1:0];
            else if (rnd[k] < COMP_LO)
                q_next[k] = COMP_LO[COMPONENT_WIDTH-1:0];
            else
                q_next[k] = rnd[k][COMPONENT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= vld_in;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    assign vld_out = d_vld_reg;
    assign quat_x  = q_reg[e2q_pkg::COMP_X];
    assign quat_y  = q_reg[e2q_pkg::COMP_Y];
    assign quat_z  = q_reg[e2q_pkg::COMP_Z];
    assign quat_w  = q_reg[e2q_pkg::COMP_W];

endmodule

// ===== rtl/euler_to_quaternion.sv =====
// Top level: yaw/pitch/roll (Q3.x radians) to unit quaternion (Q1.x).
// Depends on e2q_pkg, e2q_if, e2q_sincos and e2q_mix.
//
//   channel    dir  handshake      payload
//   angle_in   in   valid/ready    yaw_angle, pitch_angle, roll_angle
//   quat_out   out  valid/ready    quat_x, quat_y, quat_z, quat_w
//
// One item per cycle while quat_out is not stalled. The registered stages, in order:
// fold, one CORDIC step per stage, sign fix, pair product, triple product,
// sum, round/saturate. The last stage is the output register.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// A stall on quat_out freezes the whole pipeline in place, so angle_in.ready
// drops in the same cycle; nothing is dropped or repeated.
module euler_to_quaternion #(
    parameter int ANGLE_WIDTH       = 16,
    parameter int COMPONENT_WIDTH   = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    e2q_angle_if.sink    angle_in,
    e2q_quat_if.source   quat_out
);

    // Global advance: move whenever the output register is free or drained
    logic en;

    logic [e2q_pkg::LANES-1:0][ANGLE_WIDTH-1:0] angles;
    logic                                       sc_vld;
    e2q_pkg::sc_t [e2q_pkg::LANES-1:0]          sc;
    logic                                       out_vld;

    assign en             = !out_vld || quat_out.ready;
    assign angle_in.ready = en;

    assign angles[e2q_pkg::LANE_YAW]   = angle_in.yaw_angle;
    assign angles[e2q_pkg::LANE_PITCH] = angle_in.pitch_angle;
    assign angles[e2q_pkg::LANE_ROLL]  = angle_in.roll_angle;

    // Three sine/cosine lanes sharing one valid chain
    e2q_sincos #(
        .ANGLE_WIDTH       (ANGLE_WIDTH),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_sincos (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (angle_in.valid),
        .angles  (angles),
        .vld_out (sc_vld),
        .sc_out  (sc)
    );

    // Products, sums and output rounding; last register feeds quat_out
    e2q_mix #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (sc_vld),
        .sc_in   (sc),
        .vld_out (out_vld),
        .quat_x  (quat_out.quat_x),
        .quat_y  (quat_out.quat_y),
        .quat_z  (quat_out.quat_z),
        .quat_w  (quat_out.quat_w)
    );

    assign quat_out.valid = out_vld;

endmodule

// ===== rtl/e2q_checker.sv =====
// Port-level checks on the converter's handshakes, bound to the top level.
// Depends on euler_to_quaternion and its interfaces.
module e2q_checker #(
    parameter int COMPONENT_WIDTH = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [COMPONENT_WIDTH-1:0] quat_x,
    input logic signed [COMPONENT_WIDTH-1:0] quat_y,
    input logic signed [COMPONENT_WIDTH-1:0] quat_z,
    input logic signed [COMPONENT_WIDTH-1:0] quat_w
);

    // Held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(quat_w))
        else $error("result item changed while stalled");

    // Intake follows the output side exactly
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken while output stalled");

    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("intake blocked with output free");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$isunknown(out_valid))
        else $error("output valid unknown after intake");

endmodule

bind euler_to_quaternion e2q_checker #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_e2q_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (angle_in.valid),
    .in_ready  (angle_in.ready),
    .out_valid (quat_out.valid),
    .out_ready (quat_out.ready),
    .quat_x    (quat_out.quat_x),
    .quat_y    (quat_out.quat_y),
    .quat_z    (quat_out.quat_z),
    .quat_w    (quat_out.quat_w)
);
